// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 22;
    localparam int ADDR_W     = 32;
    localparam int ENTRY_W    = SIZE_W + 1;

    localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd8;
    localparam logic [ADDR_W-1:0] GAP_BYTES    = 32'd4;
    localparam logic [ADDR_W-1:0] LIMIT_RESET  = 32'd4063232;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_OOM     = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic {
        CFG_HEAP_START = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_MISS,
        S_SEND
    } state_t;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] data_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
        logic [ADDR_W-1:0] bytes_in_use;
    } out_item_t;

    typedef struct packed {
        logic              taken;
        logic [SIZE_W-1:0] bytes;
    } entry_t;

endpackage

// ===== src/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit heap allocator: walks a block table held in ram
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall/in_data; one result per request leaves
// on out_valid/out_stall/out_data. An allocate walks the block table in order,
// one ram read issued per cycle, and takes the first free block that is big
// enough; otherwise it appends a new block, or reports out of memory if the
// table is full or the heap limit is reached. A free walks the table looking
// for the taken block with the matching data address. The walk goes through
// the single ram read port over a table of at most 256 blocks; a zero-size
// allocate skips the walk. One request is worked on at a time, so a new
// request is taken only once the last result has gone to the output register.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a request that finishes while the output
// register is still full waits until out_stall drops.
// Reset empties the heap: no blocks, zero bytes in use, heap_start 0 and
// heap_limit 4063232. Writing heap_start empties the heap as well.
// The user must write configuration through cfg_write/cfg_index/cfg_data only when idle (not enforced).
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffba_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffba_pkg::out_item_t out_data,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    ffba_pkg::state_t                   state_reg, state_next;
    logic [ffba_pkg::ADDR_W-1:0]        start_reg, start_next;
    logic [ffba_pkg::ADDR_W-1:0]        limit_reg, limit_next;
    logic [ffba_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [ffba_pkg::ADDR_W-1:0]        tail_reg, tail_next;
    logic [ffba_pkg::ADDR_W-1:0]        used_reg, used_next;
    logic [ffba_pkg::CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [ffba_pkg::CNT_W-1:0]         chk_idx_reg, chk_idx_next;
    logic                               rd_vld_reg, rd_vld_next;
    logic [ffba_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    ffba_pkg::in_item_t                 req_reg, req_next;
    ffba_pkg::out_item_t                res_reg, res_next;
    logic                               out_valid_reg, out_valid_next;
    ffba_pkg::out_item_t                out_reg, out_next;

    logic                               ram_we;
    logic [ffba_pkg::IDX_W-1:0]         ram_waddr;
    ffba_pkg::entry_t                   ram_wdata;
    logic                               ram_re;
    ffba_pkg::entry_t                   ram_rdata;

    logic                               in_xfer;
    logic                               out_xfer;
    logic                               hit;
    logic                               last;
    logic [ffba_pkg::ADDR_W-1:0]        size32;
    logic [ffba_pkg::ADDR_W-1:0]        ent32;
    logic [ffba_pkg::ADDR_W:0]          end_addr;
    logic                               oom;

    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[ffba_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ffba_pkg::S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_xfer  = out_valid_reg && !out_stall;

    assign size32   = {{(ffba_pkg::ADDR_W - ffba_pkg::SIZE_W){1'b0}}, req_reg.req_size};
    assign ent32    = {{(ffba_pkg::ADDR_W - ffba_pkg::SIZE_W){1'b0}}, ram_rdata.bytes};
    assign end_addr = {1'b0, tail_reg} + {1'b0, size32} + {1'b0, ffba_pkg::HEADER_BYTES};
    assign oom      = (count_reg >= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                      || (end_addr >= {1'b0, limit_reg});
    assign ram_re   = (state_reg == ffba_pkg::S_WALK) && (rd_idx_reg < count_reg);
    assign last     = (chk_idx_reg + 1'b1 == count_reg);

    always_comb
    begin
        if (req_reg.op == ffba_pkg::OP_ALLOC)
        begin
            hit = !ram_rdata.taken && (ram_rdata.bytes >= req_reg.req_size);
        end
        else
        begin
            hit = ram_rdata.taken
                  && (addr_reg + ffba_pkg::HEADER_BYTES == req_reg.data_address);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        rd_vld_next    = 1'b0;
        addr_next      = addr_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx_reg[ffba_pkg::IDX_W-1:0];
        ram_wdata      = ram_rdata;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                ffba_pkg::CFG_HEAP_START:
                begin
                    start_next = cfg_data;
                    tail_next  = cfg_data;
                    count_next = '0;
                    used_next  = '0;
                end
                ffba_pkg::CFG_HEAP_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next    = in_data;
                    rd_idx_next = '0;
                    addr_next   = start_reg;
                    if (in_data.op == ffba_pkg::OP_ALLOC && in_data.req_size == '0)
                    begin
                        res_next   = '{result_address: '0,
                                       status: ffba_pkg::ST_ZERO,
                                       bytes_in_use: used_reg};
                        state_next = ffba_pkg::S_SEND;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ffba_pkg::S_MISS;
                    end
                    else
                    begin
                        state_next = ffba_pkg::S_WALK;
                    end
                end
            end
            ffba_pkg::S_WALK:
            begin
                if (ram_re)
                begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_vld_next  = 1'b1;
                    chk_idx_next = rd_idx_reg;
                end
                if (rd_vld_reg)
                begin
                    addr_next = addr_reg + ent32 + ffba_pkg::HEADER_BYTES
                                + ffba_pkg::GAP_BYTES;
                    if (hit)
                    begin
                        ram_we      = 1'b1;
                        rd_vld_next = 1'b0;
                        state_next  = ffba_pkg::S_SEND;
                        if (req_reg.op == ffba_pkg::OP_ALLOC)
                        begin
                            ram_wdata.taken = 1'b1;
                            used_next = used_reg + size32 + ffba_pkg::HEADER_BYTES;
                            res_next  = '{result_address: addr_reg + ffba_pkg::HEADER_BYTES,
                                          status: ffba_pkg::ST_OK,
                                          bytes_in_use: used_reg + size32
                                                        + ffba_pkg::HEADER_BYTES};
                        end
                        else
                        begin
                            ram_wdata.taken = 1'b0;
                            used_next = used_reg - ent32 - ffba_pkg::HEADER_BYTES;
                            res_next  = '{result_address: '0,
                                          status: ffba_pkg::ST_OK,
                                          bytes_in_use: used_reg - ent32
                                                        - ffba_pkg::HEADER_BYTES};
                        end
                    end
                    else if (last)
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = ffba_pkg::S_MISS;
                    end
                end
            end
            ffba_pkg::S_MISS:
            begin
                state_next = ffba_pkg::S_SEND;
                if (req_reg.op == ffba_pkg::OP_FREE)
                begin
                    res_next = '{result_address: '0,
                                 status: ffba_pkg::ST_UNKNOWN,
                                 bytes_in_use: used_reg};
                end
                else if (oom)
                begin
                    res_next = '{result_address: '0,
                                 status: ffba_pkg::ST_OOM,
                                 bytes_in_use: used_reg};
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[ffba_pkg::IDX_W-1:0];
                    ram_wdata.taken = 1'b1;
                    ram_wdata.bytes = req_reg.req_size;
                    count_next      = count_reg + 1'b1;
                    tail_next       = tail_reg + size32 + ffba_pkg::HEADER_BYTES
                                      + ffba_pkg::GAP_BYTES;
                    used_next       = used_reg + size32 + ffba_pkg::HEADER_BYTES
                                      + ffba_pkg::GAP_BYTES;
                    res_next        = '{result_address: tail_reg + ffba_pkg::HEADER_BYTES,
                                        status: ffba_pkg::ST_OK,
                                        bytes_in_use: used_reg + size32
                                                      + ffba_pkg::HEADER_BYTES
                                                      + ffba_pkg::GAP_BYTES};
                end
            end
            ffba_pkg::S_SEND:
            begin
                // output register free or emptied by this transfer
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ffba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            limit_reg     <= ffba_pkg::LIMIT_RESET;
            count_reg     <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            tail_reg      <= tail_next;
            used_reg      <= used_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        addr_reg    <= addr_next;
        req_reg     <= req_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // table never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
        else $error("block count beyond table depth");

    // ram is only written while a request is in progress
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ffba_pkg::S_WALK || state_reg == ffba_pkg::S_MISS))
        else $error("ram write outside a request");

    // every entry checked lies inside the laid-out table
    a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (chk_idx_reg < count_reg && state_reg == ffba_pkg::S_WALK))
        else $error("check of an entry beyond the table");

    // a zero-size allocate goes straight to the result
    a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_data.op == ffba_pkg::OP_ALLOC && in_data.req_size == '0)
        |=> (state_reg == ffba_pkg::S_SEND && res_reg.status == ffba_pkg::ST_ZERO))
        else $error("zero-size allocate not answered at once");

endmodule

// ===== dv/tb_first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit
// self-checking bench for the first-fit block allocator
// ----------------------------------------------------------------------------
// Requests are queued by a sequencing process and presented by a driver on
// the falling edge. A monitor on the rising edge keeps its own copy of the
// block table, predicts the reply of every accepted request and checks each
// reply field against it. Directed requests hit the size boundaries, reuse,
// double free and unknown addresses; random phases then run under several
// heap placements (address wrap, a tiny heap, an unusable heap, a full table)
// with varied sender gaps, receiver stalls and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 1500;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_HEAP_START;
    logic [31:0] cfg_data  = '0;

    // model of the heap
    logic [ADDR_W-1:0] cur_heap_start;
    logic [ADDR_W-1:0] cur_heap_limit;
    bit                tbl_taken [MAX_BLOCKS];
    logic [SIZE_W-1:0] tbl_bytes [MAX_BLOCKS];
    int                tbl_count;
    logic [ADDR_W-1:0] append_addr;
    logic [ADDR_W-1:0] bytes_used;
    logic [ADDR_W-1:0] live_addrs [$];
    logic [ADDR_W-1:0] last_freed;

    in_item_t  request_backlog [$];
    out_item_t pending_replies [$];

    bit req_sent;
    int requests_issued;
    int replies_seen;
    int error_count;
    int cycle_count;
    int peak_blocks;
    int status_tally [4];
    int send_idle_pct;
    int stall_pct;
    int hold_orders;
    int hold_served;
    int hold_left;

    first_fit_block_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void empty_heap();
        tbl_count   = 0;
        append_addr = cur_heap_start;
        bytes_used  = '0;
        live_addrs.delete();
    endfunction

    function automatic out_item_t model_heap_request(in_item_t req);
        out_item_t         rep;
        logic [ADDR_W-1:0] walk;
        logic [ADDR_W:0]   end_addr;
        bit                done;
        int                hit;
        rep  = '0;
        walk = cur_heap_start;
        done = 1'b0;
        hit  = -1;
        if (req.op == OP_FREE) begin
            rep.status = ST_UNKNOWN;
            for (int i = 0; i < tbl_count && !done; i++) begin
                if (tbl_taken[i] && walk + HEADER_BYTES == req.data_address) begin
                    tbl_taken[i] = 1'b0;
                    bytes_used  -= 32'(tbl_bytes[i]) + HEADER_BYTES;
                    rep.status   = ST_OK;
                    last_freed   = req.data_address;
                    done         = 1'b1;
                end
                walk += 32'(tbl_bytes[i]) + HEADER_BYTES + GAP_BYTES;
            end
            if (done) begin
                foreach (live_addrs[k])
                    if (live_addrs[k] == req.data_address)
                        hit = k;
                if (hit >= 0)
                    live_addrs.delete(hit);
            end
        end
        else if (req.req_size == '0) begin
            rep.status = ST_ZERO;
        end
        else begin
            for (int i = 0; i < tbl_count && !done; i++) begin
                if (!tbl_taken[i] && tbl_bytes[i] >= req.req_size) begin
                    tbl_taken[i]       = 1'b1;
                    bytes_used        += 32'(req.req_size) + HEADER_BYTES;
                    rep.result_address = walk + HEADER_BYTES;
                    done               = 1'b1;
                end
                else begin
                    walk += 32'(tbl_bytes[i]) + HEADER_BYTES + GAP_BYTES;
                end
            end
            if (!done) begin
                end_addr = {1'b0, append_addr} + 33'(req.req_size) + {1'b0, HEADER_BYTES};
                if (tbl_count >= MAX_BLOCKS || end_addr >= {1'b0, cur_heap_limit}) begin
                    rep.status = ST_OOM;
                end
                else begin
                    tbl_taken[tbl_count] = 1'b1;
                    tbl_bytes[tbl_count] = req.req_size;
                    tbl_count++;
                    rep.result_address = append_addr + HEADER_BYTES;
                    append_addr       += 32'(req.req_size) + HEADER_BYTES + GAP_BYTES;
                    bytes_used        += 32'(req.req_size) + HEADER_BYTES + GAP_BYTES;
                    done               = 1'b1;
                    if (tbl_count > peak_blocks)
                        peak_blocks = tbl_count;
                end
            end
            if (done)
                live_addrs.push_back(rep.result_address);
        end
        rep.bytes_in_use = bytes_used;
        return rep;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 70)
            return SIZE_W'($urandom_range(1, 64));
        if (r < 85)
            return SIZE_W'($urandom_range(65, 4096));
        return SIZE_W'($urandom_range(1, SIZE_MAX));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int r;
        r = $urandom_range(0, 99);
        if (live_addrs.size() != 0 && r < 80)
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        if (r < 86)
            return last_freed;
        if (r < 93)
            return cur_heap_start + HEADER_BYTES + 32'($urandom_range(0, 64));
        return $urandom;
    endfunction

    task automatic queue_request(op_t op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        in_item_t req;
        while (request_backlog.size() >= 2)
            @(negedge clk);
        req.op           = op;
        req.req_size     = size;
        req.data_address = addr;
        request_backlog.push_back(req);
        requests_issued++;
    endtask

    task automatic run_random(int count, int alloc_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < alloc_pct)
                queue_request(OP_ALLOC, pick_size(), $urandom);
            else
                queue_request(OP_FREE, SIZE_W'($urandom_range(0, SIZE_MAX)), pick_free_addr());
        end
    endtask

    task automatic drain_replies();
        while (replies_seen != requests_issued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic place_heap(logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] limit);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_HEAP_START;
        cfg_data  <= start;
        @(negedge clk);
        cfg_index <= CFG_HEAP_LIMIT;
        cfg_data  <= limit;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_sent) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_data  <= request_backlog.pop_front();
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk) begin
        if (hold_left == 0 && hold_served != hold_orders) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        out_item_t want;
        req_sent = 1'b0;
        if (rst_n) begin
            if (cfg_write) begin
                if (cfg_index == CFG_HEAP_START) begin
                    cur_heap_start = cfg_data;
                    empty_heap();
                end
                else begin
                    cur_heap_limit = cfg_data;
                end
            end
            req_sent = in_valid && !in_stall;
            if (req_sent)
                pending_replies.push_back(model_heap_request(in_data));
            if (out_valid && !out_stall) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    $error("result transfer with nothing expected: %h", out_data);
                    error_count++;
                end
                else begin
                    want = pending_replies.pop_front();
                    status_tally[want.status]++;
                    if (out_data.result_address !== want.result_address) begin
                        $error("result_address: expected %h, got %h",
                               want.result_address, out_data.result_address);
                        error_count++;
                    end
                    if (out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        error_count++;
                    end
                    if (out_data.bytes_in_use !== want.bytes_in_use) begin
                        $error("bytes_in_use: expected %h, got %h",
                               want.bytes_in_use, out_data.bytes_in_use);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d of %0d results seen",
                   cycle_count, replies_seen, requests_issued);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        cur_heap_start = '0;
        cur_heap_limit = LIMIT_RESET;
        last_freed     = '0;
        empty_heap();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // size boundaries against the reset heap limit
        queue_request(OP_ALLOC, '0, $urandom);
        queue_request(OP_ALLOC, SIZE_MAX, $urandom);
        queue_request(OP_ALLOC, 22'd4063224, $urandom);
        queue_request(OP_ALLOC, 22'd4063223, $urandom);
        queue_request(OP_ALLOC, 22'd1, $urandom);
        queue_request(OP_FREE, '0, 32'd8);
        queue_request(OP_ALLOC, 22'd100, $urandom);
        queue_request(OP_FREE, SIZE_MAX, 32'd8);
        queue_request(OP_FREE, '0, 32'd8);
        queue_request(OP_FREE, '0, 32'd0);
        queue_request(OP_FREE, SIZE_MAX, 32'hFFFF_FFFF);
        drain_replies();

        // reuse and append ordering
        place_heap('0, '1);
        queue_request(OP_ALLOC, 22'd1, $urandom);
        queue_request(OP_ALLOC, 22'd2, $urandom);
        queue_request(OP_ALLOC, 22'd3, $urandom);
        queue_request(OP_FREE, '0, 32'd21);
        queue_request(OP_ALLOC, 22'd3, $urandom);
        queue_request(OP_ALLOC, 22'd2, $urandom);
        queue_request(OP_FREE, '0, 32'd8);
        queue_request(OP_ALLOC, SIZE_MAX, $urandom);
        queue_request(OP_ALLOC, 22'd1, $urandom);
        queue_request(OP_FREE, '0, 32'd9);
        queue_request(OP_FREE, SIZE_MAX, 32'd35);
        drain_replies();

        place_heap('0, '1);
        run_random(200, 60);
        drain_replies();

        send_idle_pct = 53;
        place_heap(32'($urandom_range(0, 32'h00FF_FFFF)),
                   32'($urandom_range(32'h0010_0000, 32'h0400_0000)));
        run_random(200, 60);
        drain_replies();

        // first block ends just below the top so the next one wraps to address 1
        send_idle_pct = 0;
        stall_pct     = 53;
        place_heap(32'hFFFF_FF00, '1);
        queue_request(OP_ALLOC, 22'h0000F5, $urandom);
        run_random(200, 60);
        drain_replies();

        send_idle_pct = 35;
        stall_pct     = 35;
        place_heap(32'h8000_0000, 32'h8000_4000);
        run_random(200, 60);
        drain_replies();

        // allocation heavy, runs the table full
        send_idle_pct = 53;
        stall_pct     = 0;
        place_heap(32'h1000_0000, '1);
        run_random(350, 95);
        drain_replies();

        send_idle_pct = 0;
        stall_pct     = 53;
        place_heap('1, '1);
        run_random(30, 60);
        drain_replies();
        place_heap('0, '0);
        run_random(30, 60);
        drain_replies();

        stall_pct = 0;
        place_heap('0, LIMIT_RESET);
        hold_orders++;
        run_random(100, 60);
        drain_replies();
        send_idle_pct = 35;
        stall_pct     = 35;
        run_random(100, 60);
        drain_replies();

        repeat (20) @(negedge clk);
        if (pending_replies.size() != 0) begin
            $error("%0d results never arrived", pending_replies.size());
            error_count++;
        end
        $display("covered %0d requests: %0d ok, %0d zero size, %0d out of memory, %0d unknown",
                 requests_issued, status_tally[ST_OK], status_tally[ST_ZERO],
                 status_tally[ST_OOM], status_tally[ST_UNKNOWN]);
        $display("block table peaked at %0d of %0d entries; one %0d-cycle result hold-off",
                 peak_blocks, MAX_BLOCKS, HOLD_CYCLES);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/ffba_pkg.sv
src/ffba_ram.sv
src/first_fit_block_allocator_unit.sv
dv/tb_first_fit_block_allocator_unit.sv
